/* rtl/core/rtc2ep_pkg.sv */
// shared types, constants and helper functions for the rtc snapshot to epoch pipeline
package rtc2ep_pkg;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ABSENT   = 3'd1,
		ST_INVALID  = 3'd2,
		ST_READFAIL = 3'd3,
		ST_NOSYNC   = 3'd4
	} status_t;

	// year offset from 2000 below which the clock is taken as never synced
	localparam logic [8:0] YEAR_MIN_OFS = 9'd24;
	// the year offset stays below 400 so the 400-year era is always 5;
	// days from 1970-01-01 to the start of that era (2000-03-01)
	localparam int DAYS_BASE_INT = 5 * 146097 - 719468;
	localparam logic [16:0] DAYS_BASE = 17'(DAYS_BASE_INT);
	localparam logic [16:0] SEC_PER_DAY = 17'd86400;

	typedef struct packed {
		logic       read_ok;
		logic       time_valid;
		logic [7:0] sec_reg;
		logic [7:0] min_reg;
		logic [7:0] hour_reg;
		logic [7:0] date_reg;
		logic [7:0] month_reg;
		logic [7:0] year_reg;
	} snap_t;

	typedef struct packed {
		status_t    status;
		logic [6:0] sec;
		logic [6:0] mnt;
		logic [5:0] hr;
		logic [4:0] day;
		logic [3:0] mon;
		logic [8:0] yr;
	} dec_t;

	typedef struct packed {
		status_t     status;
		logic [16:0] days;
		logic [17:0] tod;
	} cal_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] epoch;
	} res_t;

	function automatic logic [7:0] bcd_value(input logic [7:0] b);
		logic [7:0] hi;
		hi = {4'd0, b[7:4]};
		return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
	endfunction

	// day of the March-based year on which each month starts
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/rtc2ep_ifs.sv */
// handshake interfaces for the snapshot, result and configuration channels
interface rtc2ep_snap_if;
	logic       valid;
	logic       ready;
	logic       read_ok;
	logic       time_valid;
	logic [7:0] sec_reg;
	logic [7:0] min_reg;
	logic [7:0] hour_reg;
	logic [7:0] date_reg;
	logic [7:0] month_reg;
	logic [7:0] year_reg;
	modport source (output valid, read_ok, time_valid, sec_reg, min_reg, hour_reg, date_reg,
		month_reg, year_reg, input ready);
	modport sink (input valid, read_ok, time_valid, sec_reg, min_reg, hour_reg, date_reg,
		month_reg, year_reg, output ready);
endinterface

interface rtc2ep_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] epoch_seconds;
	modport source (output valid, status, epoch_seconds, input ready);
	modport sink (input valid, status, epoch_seconds, output ready);
endinterface

interface rtc2ep_cfg_if;
	logic valid;
	logic ready;
	logic rtc_present;
	modport source (output valid, rtc_present, input ready);
	modport sink (input valid, rtc_present, output ready);
endinterface

/* rtl/core/rtc2ep_decode.sv */
// stage 1: bcd field decode, hour mode handling and status priority
module rtc2ep_decode import rtc2ep_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  present,
	input  logic  in_valid,
	output logic  in_ready,
	input  snap_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output dec_t  out_data
);

	logic       v_s1;
	dec_t       d_s1;
	dec_t       dec;
	logic [7:0] sec_b;
	logic [7:0] mnt_b;
	logic [7:0] hr_b;
	logic [7:0] day_b;
	logic [7:0] mon_b;
	logic [8:0] yr_b;

	always_comb begin
		sec_b = bcd_value({1'b0, in_data.sec_reg[6:0]});
		mnt_b = bcd_value({1'b0, in_data.min_reg[6:0]});
		day_b = bcd_value({2'b0, in_data.date_reg[5:0]});
		mon_b = bcd_value({3'b0, in_data.month_reg[4:0]});
		yr_b  = {1'b0, bcd_value(in_data.year_reg)} + (in_data.month_reg[7] ? 9'd100 : 9'd0);
		if (in_data.hour_reg[6]) begin
			hr_b = bcd_value({3'b0, in_data.hour_reg[4:0]});
			// twelve o'clock counts as zero before the pm offset
			if (hr_b == 8'd12)
				hr_b = 8'd0;
			if (in_data.hour_reg[5])
				hr_b = hr_b + 8'd12;
		end else begin
			hr_b = bcd_value({2'b0, in_data.hour_reg[5:0]});
		end

		if (!present)
			dec.status = ST_ABSENT;
		else if (!in_data.time_valid)
			dec.status = ST_INVALID;
		else if (!in_data.read_ok)
			dec.status = ST_READFAIL;
		else if (yr_b < YEAR_MIN_OFS || mon_b < 8'd1 || mon_b > 8'd12 ||
			day_b < 8'd1 || day_b > 8'd31)
			dec.status = ST_NOSYNC;
		else
			dec.status = ST_OK;

		dec.sec = sec_b[6:0];
		dec.mnt = mnt_b[6:0];
		dec.hr  = hr_b[5:0];
		dec.day = day_b[4:0];
		dec.mon = mon_b[3:0];
		dec.yr  = yr_b;
	end

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_ready)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			d_s1 <= dec;
	end

	assign out_valid = v_s1;
	assign out_data  = d_s1;

endmodule

/* rtl/core/rtc2ep_days.sv */
// stages 2 and 3: day of year, time of day, then day count since 1970
module rtc2ep_days import rtc2ep_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  dec_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output cal_t out_data
);

	typedef struct packed {
		status_t     status;
		logic [8:0]  yoe;
		logic [8:0]  doy;
		logic [17:0] tod;
	} doy_t;

	logic        v_s2;
	logic        v_s3;
	logic        rdy_s2;
	logic        rdy_s3;
	doy_t        d_s2;
	cal_t        d_s3;
	doy_t        nxt2;
	cal_t        nxt3;
	logic [3:0]  mp;
	logic [1:0]  cent;

	always_comb begin
		nxt2.status = in_data.status;
		// march-based year: january and february belong to the year before
		nxt2.yoe = in_data.yr - ((in_data.mon <= 4'd2) ? 9'd1 : 9'd0);
		mp = (in_data.mon > 4'd2) ? in_data.mon - 4'd3 : in_data.mon + 4'd9;
		nxt2.doy = month_start(mp) + {4'd0, in_data.day} - 9'd1;
		nxt2.tod = 18'(in_data.hr) * 18'd3600 + 18'(in_data.mnt) * 18'd60 + 18'(in_data.sec);
	end

	always_comb begin
		if (d_s2.yoe >= 9'd200)
			cent = 2'd2;
		else if (d_s2.yoe >= 9'd100)
			cent = 2'd1;
		else
			cent = 2'd0;
		nxt3.status = d_s2.status;
		nxt3.days = DAYS_BASE + 17'(d_s2.yoe) * 17'd365 + 17'(d_s2.yoe >> 2) - 17'(cent)
			+ 17'(d_s2.doy);
		nxt3.tod = d_s2.tod;
	end

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s2)
				v_s2 <= in_valid;
			if (rdy_s3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid)
			d_s2 <= nxt2;
		if (rdy_s3 && v_s2)
			d_s3 <= nxt3;
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;

endmodule

/* rtl/core/rtc2ep_epoch.sv */
// stages 4 and 5: days times seconds per day, then add time of day into the result register
module rtc2ep_epoch import rtc2ep_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cal_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);

	typedef struct packed {
		status_t     status;
		logic [31:0] prod;
		logic [17:0] tod;
	} prod_t;

	logic        v_s4;
	logic        v_s5;
	logic        rdy_s4;
	logic        rdy_s5;
	prod_t       d_s4;
	res_t        d_s5;
	prod_t       nxt4;
	res_t        nxt5;
	logic [33:0] prod_full;

	always_comb begin
		prod_full   = 34'(in_data.days) * 34'(SEC_PER_DAY);
		nxt4.status = in_data.status;
		nxt4.prod   = prod_full[31:0];
		nxt4.tod    = in_data.tod;
	end

	always_comb begin
		nxt5.status = d_s4.status;
		// any failure reports epoch zero; the sum wraps at 32 bits
		if (d_s4.status == ST_OK)
			nxt5.epoch = d_s4.prod + 32'(d_s4.tod);
		else
			nxt5.epoch = 32'd0;
	end

	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4)
				v_s4 <= in_valid;
			if (rdy_s5)
				v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid)
			d_s4 <= nxt4;
		if (rdy_s5 && v_s4)
			d_s5 <= nxt5;
	end

	assign out_valid = v_s5;
	assign out_data  = d_s5;

endmodule

/* rtl/core/bcd_rtc_regs_to_unix_epoch_unit.sv */
// top level: rtc register snapshot to unix epoch, five-stage pipeline
//
//  channel  dir  payload                                       transfer when
//  snap     in   read_ok, time_valid, six raw bcd registers    valid && ready
//  res      out  status (3b), epoch_seconds (32b)              valid && ready
//  cfg      in   rtc_present (1b)                              valid && ready
//
// five register stages: decode, day of year and time of day, day count,
// multiply by seconds per day, final add into the output register.
// one snapshot per cycle while res is not stalled; res.valid rises once it has passed all five register stages.
// arst_n clears the stage valid bits and rtc_present; payload is not reset.
// each stage holds while the one after it is full and stalled, so res.ready
// low backs up stage by stage; snap.ready stays high while any bubble remains.
module bcd_rtc_regs_to_unix_epoch_unit import rtc2ep_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	rtc2ep_cfg_if.sink   cfg,
	rtc2ep_snap_if.sink  snap,
	rtc2ep_res_if.source res
);

	logic rtc_present_q;
	snap_t snap_data;
	logic dec_valid;
	logic dec_ready;
	dec_t dec_data;
	logic cal_valid;
	logic cal_ready;
	cal_t cal_data;
	res_t res_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rtc_present_q <= 1'b0;
		else if (cfg.valid)
			rtc_present_q <= cfg.rtc_present;
	end

	always_comb begin
		snap_data.read_ok    = snap.read_ok;
		snap_data.time_valid = snap.time_valid;
		snap_data.sec_reg    = snap.sec_reg;
		snap_data.min_reg    = snap.min_reg;
		snap_data.hour_reg   = snap.hour_reg;
		snap_data.date_reg   = snap.date_reg;
		snap_data.month_reg  = snap.month_reg;
		snap_data.year_reg   = snap.year_reg;
	end

	rtc2ep_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.present   (rtc_present_q),
		.in_valid  (snap.valid),
		.in_ready  (snap.ready),
		.in_data   (snap_data),
		.out_valid (dec_valid),
		.out_ready (dec_ready),
		.out_data  (dec_data)
	);

	rtc2ep_days u_days (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_data   (dec_data),
		.out_valid (cal_valid),
		.out_ready (cal_ready),
		.out_data  (cal_data)
	);

	rtc2ep_epoch u_epoch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cal_valid),
		.in_ready  (cal_ready),
		.in_data   (cal_data),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (res_data)
	);

	assign res.status        = res_data.status;
	assign res.epoch_seconds = res_data.epoch;

	// a failed conversion never carries a nonzero epoch
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != ST_OK |-> res.epoch_seconds == 32'd0)
		else $error("nonzero epoch with failure status");

	// with the output free, every stage can advance, so the input must be open
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid || res.ready |-> snap.ready)
		else $error("input stalled while output stage free");

	// the status code never leaves the defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.status == ST_OK || res.status == ST_ABSENT ||
			res.status == ST_INVALID || res.status == ST_READFAIL ||
			res.status == ST_NOSYNC)
		else $error("undefined status code");

endmodule
